FILE: design/utf8d_pkg.sv
// Shared widths and code point constants for the UTF-8 to UTF-32 decoder.
`default_nettype none
package utf8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CP_W     = 21;
    localparam int unsigned TDATA_W  = 24;
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned CNT_W    = 3;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_END         = 21'h000000;

    // Lead byte prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [4:0] LEAD4_PFX = 5'b11110;

endpackage
`default_nettype wire

FILE: design/utf8_to_utf32_decoder_core.sv
// UTF-8 byte stream to UTF-32 code point decoder, top level.
// An accepted byte's first result is registered in the burst register and shows on the output in the next cycle.
// Throughput: one input word per cycle while each word gives at most one result and the
// output is not stalled; a word that gives more results holds the input side while the
// result burst register drains one word per cycle as the output takes them.
// Reset: synchronous, active low; clears the open sequence and empties the burst register.
`default_nettype none
module utf8_to_utf32_decoder_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] byte_in
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [utf8d_pkg::TDATA_W-1:0]      m_axis_tdata,   // [20:0] code_point
    output logic                               m_axis_tlast,   // last_in_run
    output logic                               m_axis_tuser    // end_of_string
);
    import utf8d_pkg::*;

    // Decode state
    logic [1:0]        r_needed, n_needed;
    logic [1:0]        r_held,   n_held;
    logic [BYTE_W-1:0] r_h0, n_h0, r_h1, n_h1;
    logic [CP_W-1:0]   r_pv, n_pv;

    // Result burst register, entry 0 is on the output
    logic [CP_W-1:0]   r_bcp  [MAX_RES];
    logic              r_beos [MAX_RES];
    logic [CNT_W-1:0]  r_cnt;
    logic [CP_W-1:0]   n_bcp  [MAX_RES];
    logic              n_beos [MAX_RES];
    logic [CNT_W-1:0]  n_k;

    logic              w_accept;
    logic              w_pop;
    logic [BYTE_W-1:0] w_b;
    logic [CP_W-1:0]   w_pv_ext;

    assign w_b           = s_axis_tdata;
    assign m_axis_tvalid = (r_cnt != '0);
    assign w_pop         = m_axis_tvalid & m_axis_tready;
    assign s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && m_axis_tready);
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    assign m_axis_tdata  = {{(TDATA_W-CP_W){1'b0}}, r_bcp[0]};
    assign m_axis_tuser  = r_beos[0];
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));

    assign w_pv_ext = {r_pv[CP_W-7:0], w_b[5:0]};

    always_comb begin
        n_needed = r_needed;
        n_held   = r_held;
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_pv     = r_pv;
        n_k      = '0;
        for (int e = 0; e < MAX_RES; e++) begin
            n_bcp[e]  = CP_END;
            n_beos[e] = 1'b0;
        end

        if (r_needed != 2'd0) begin
            if (w_b != '0) begin
                n_needed = r_needed - 2'd1;
                if (r_needed == 2'd1) begin
                    n_bcp[n_k[1:0]] = w_pv_ext;
                    n_k             = n_k + CNT_W'(1);
                    n_held          = 2'd0;
                    n_pv            = '0;
                end else begin
                    n_pv = w_pv_ext;
                    // hold the continuation for a possible re-decode
                    if (r_held < 2'd2) begin
                        if (r_held == 2'd0) n_h0 = w_b;
                        else                n_h1 = w_b;
                        n_held = r_held + 2'd1;
                    end
                end
            end else begin
                // sequence cut short: lead is malformed, re-decode held bytes
                n_bcp[n_k[1:0]] = CP_REPLACEMENT;
                n_k             = n_k + CNT_W'(1);
                if (r_held != 2'd0) begin
                    if ((r_h0[7:5] == LEAD2_PFX) && (r_held == 2'd2)) begin
                        n_bcp[n_k[1:0]] = CP_W'({r_h0[4:0], r_h1[5:0]});
                        n_k             = n_k + CNT_W'(1);
                    end else begin
                        n_bcp[n_k[1:0]] = r_h0[7] ? CP_REPLACEMENT : CP_W'(r_h0);
                        n_k             = n_k + CNT_W'(1);
                        if (r_held == 2'd2) begin
                            n_bcp[n_k[1:0]] = r_h1[7] ? CP_REPLACEMENT : CP_W'(r_h1);
                            n_k             = n_k + CNT_W'(1);
                        end
                    end
                end
                n_bcp[n_k[1:0]]  = CP_END;
                n_beos[n_k[1:0]] = 1'b1;
                n_k              = n_k + CNT_W'(1);
                n_needed         = 2'd0;
                n_held           = 2'd0;
                n_pv             = '0;
            end
        end else if (w_b == '0) begin
            n_bcp[0]  = CP_END;
            n_beos[0] = 1'b1;
            n_k       = CNT_W'(1);
        end else if (!w_b[7]) begin
            n_bcp[0] = CP_W'(w_b);
            n_k      = CNT_W'(1);
        end else if (w_b[7:5] == LEAD2_PFX) begin
            n_needed = 2'd1;
            n_held   = 2'd0;
            n_pv     = CP_W'(w_b[4:0]);
        end else if (w_b[7:4] == LEAD3_PFX) begin
            n_needed = 2'd2;
            n_held   = 2'd0;
            n_pv     = CP_W'(w_b[3:0]);
        end else if (w_b[7:3] == LEAD4_PFX) begin
            n_needed = 2'd3;
            n_held   = 2'd0;
            n_pv     = CP_W'(w_b[2:0]);
        end else begin
            n_bcp[0] = CP_REPLACEMENT;
            n_k      = CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed <= '0;
            r_held   <= '0;
            r_pv     <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_accept) begin
                r_needed <= n_needed;
                r_held   <= n_held;
                r_pv     <= n_pv;
                r_cnt    <= n_k;
            end else if (w_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_h0 <= n_h0;
            r_h1 <= n_h1;
            for (int e = 0; e < MAX_RES; e++) begin
                r_bcp[e]  <= n_bcp[e];
                r_beos[e] <= n_beos[e];
            end
        end else if (w_pop) begin
            // advance the burst by one word
            for (int e = 0; e < MAX_RES - 1; e++) begin
                r_bcp[e]  <= r_bcp[e+1];
                r_beos[e] <= r_beos[e+1];
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb_utf8_to_utf32_decoder_core.sv
// Self-checking testbench for the UTF-8 to UTF-32 decoder core.
`timescale 1ns / 1ps

import utf8d_pkg::*;

typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            eos;
    logic            last;
} t_cp_word;

class t_cp_scoreboard;
    // decoder state as the block should hold it
    bit [1:0]      need_cnt;
    bit [1:0]      held_cnt;
    bit [7:0]      held_q [2];
    bit [CP_W-1:0] acc_cp;

    t_cp_word burst_q [$];
    t_cp_word due_q [$];

    int n_bytes;
    int n_words;
    int n_strings;
    int n_cut;
    int n_errors;

    function void emit(logic [CP_W-1:0] cp, logic eos);
        t_cp_word w;
        w.cp   = cp;
        w.eos  = eos;
        w.last = 1'b0;
        burst_q = {burst_q, w};
        if (eos)
            n_strings++;
    endfunction

    // Work out every word that one accepted byte should produce.
    function void note_byte(logic [7:0] b);
        int i;
        bit [7:0] c;
        n_bytes++;
        burst_q.delete();
        if (need_cnt != 0) begin
            if (b != 8'h00) begin
                acc_cp = (acc_cp << 6) | CP_W'(b[5:0]);
                need_cnt--;
                if (need_cnt == 0) begin
                    emit(acc_cp, 1'b0);
                    held_cnt = 0;
                    acc_cp   = '0;
                end else if (held_cnt < 2) begin
                    held_q[held_cnt] = b;
                    held_cnt++;
                end
            end else begin
                // cut short: replace the lead, decode held bytes afresh, close
                n_cut++;
                emit(CP_REPLACEMENT, 1'b0);
                i = 0;
                while (i < held_cnt) begin
                    c = held_q[i];
                    if (c < 8'h80) begin
                        emit(CP_W'(c), 1'b0);
                        i++;
                    end else if (c[7:5] == LEAD2_PFX && i + 1 < held_cnt) begin
                        emit(CP_W'({c[4:0], held_q[i+1][5:0]}), 1'b0);
                        i += 2;
                    end else begin
                        emit(CP_REPLACEMENT, 1'b0);
                        i++;
                    end
                end
                emit(CP_END, 1'b1);
                need_cnt = 0;
                held_cnt = 0;
                acc_cp   = '0;
            end
        end else if (b == 8'h00) begin
            emit(CP_END, 1'b1);
        end else if (b < 8'h80) begin
            emit(CP_W'(b), 1'b0);
        end else if (b[7:5] == LEAD2_PFX) begin
            need_cnt = 1;
            held_cnt = 0;
            acc_cp   = CP_W'(b[4:0]);
        end else if (b[7:4] == LEAD3_PFX) begin
            need_cnt = 2;
            held_cnt = 0;
            acc_cp   = CP_W'(b[3:0]);
        end else if (b[7:3] == LEAD4_PFX) begin
            need_cnt = 3;
            held_cnt = 0;
            acc_cp   = CP_W'(b[2:0]);
        end else begin
            emit(CP_REPLACEMENT, 1'b0);
        end
        if (burst_q.size() > 0)
            burst_q[burst_q.size()-1].last = 1'b1;
        due_q = {due_q, burst_q};
    endfunction

    function void check_word(logic [TDATA_W-1:0] tdata, logic tlast, logic tuser);
        t_cp_word w;
        logic [TDATA_W-1:0] exp_data;
        n_words++;
        if (due_q.size() == 0) begin
            $display("%0t: unexpected word tdata=%h tlast=%b tuser=%b",
                     $time, tdata, tlast, tuser);
            n_errors++;
            return;
        end
        w = due_q.pop_front();
        exp_data = TDATA_W'(w.cp);
        if (tdata !== exp_data) begin
            $display("%0t: code point mismatch: expected %h, actual %h",
                     $time, exp_data, tdata);
            n_errors++;
        end
        if (tuser !== w.eos) begin
            $display("%0t: end-of-string mismatch: expected %b, actual %b",
                     $time, w.eos, tuser);
            n_errors++;
        end
        if (tlast !== w.last) begin
            $display("%0t: last-in-run mismatch: expected %b, actual %b",
                     $time, w.last, tlast);
            n_errors++;
        end
    endfunction
endclass

module tb_utf8_to_utf32_decoder_core;

    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_AFTER   = 260;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_LIMIT   = 500;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata = '0;   // [7:0] byte_in
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;        // [20:0] code_point
    logic                m_axis_tlast;        // last_in_run
    logic                m_axis_tuser;        // end_of_string

    t_cp_scoreboard sb = new;
    bit calm = 1'b0;
    int sent_cnt = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    utf8_to_utf32_decoder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
    end

    // Stall the result side in random bursts.
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (!calm && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
        m_axis_tready <= (stall_left == 0);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        sent_cnt++;
    endtask

    function automatic logic [7:0] cont_byte();
        // mostly proper continuations, now and then any non-zero byte
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(1, 255));
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_byte(int len);
        case (len)
            2:       return {LEAD2_PFX, 5'($urandom)};
            3:       return {LEAD3_PFX, 4'($urandom)};
            default: return {LEAD4_PFX, 3'($urandom)};
        endcase
    endfunction

    task automatic send_seq(int len);
        if (len == 1) begin
            send_byte(8'($urandom_range(1, 127)));
        end else begin
            send_byte(lead_byte(len));
            repeat (len - 1) send_byte(cont_byte());
        end
    endtask

    // Open a sequence, hold fewer bytes than it needs, then terminate.
    task automatic send_cut_seq();
        int len;
        int held;
        len  = $urandom_range(2, 4);
        held = $urandom_range(0, len - 2);
        send_byte(lead_byte(len));
        for (int k = 0; k < held; k++) begin
            if (k == 0 && $urandom_range(0, 2) == 0)
                send_byte(lead_byte(2));
            else
                send_byte(8'($urandom_range(1, 255)));
        end
        send_byte(8'h00);
    endtask

    initial begin
        logic [7:0] directed_q [$];
        int pick;
        int stop_at;
        directed_q = {8'h00, 8'h41, 8'h7F, 8'h80, 8'hF8, 8'hFF,
                      8'hC2, 8'hA9,
                      8'hE2, 8'h82, 8'hAC,
                      8'hF7, 8'hBF, 8'hBF, 8'hBF,
                      8'hF0, 8'h00,
                      8'hF0, 8'hC3, 8'hA9, 8'h00,
                      8'hE0, 8'h41, 8'h00,
                      8'hF0, 8'hC5, 8'h00};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_q[k])
            send_byte(directed_q[k]);

        stop_at = sent_cnt + RANDOM_ITEMS;
        while (sent_cnt < stop_at) begin
            if (sent_cnt >= stop_at - RANDOM_ITEMS + CALM_AFTER)
                calm = 1'b1;
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4: send_seq($urandom_range(1, 4));
                5:             send_byte(8'($urandom_range(0, 255)));
                6:             send_byte(8'h00);
                7:             send_cut_seq();
                8: begin
                    if ($urandom_range(0, 1) == 0)
                        send_byte(8'($urandom_range(8'h80, 8'hBF)));
                    else
                        send_byte(8'($urandom_range(8'hF8, 8'hFF)));
                end
                default: begin
                    // lead followed by arbitrary non-zero bytes
                    send_byte(lead_byte($urandom_range(2, 4)));
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(1, 255)));
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        while (sb.due_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.due_q.size() != 0) begin
            $display("%0t: %0d expected words never arrived, first code point %h",
                     $time, sb.due_q.size(), sb.due_q[0].cp);
            sb.n_errors++;
        end

        $display("Fed %0d bytes and checked %0d code point words over %0d strings.",
                 sb.n_bytes, sb.n_words, sb.n_strings);
        $display("Sequences cut by a terminator: %0d; field mismatches: %0d.",
                 sb.n_cut, sb.n_errors);
        if (sb.n_errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
